// ----- hw/rtl/hhs_pkg.sv -----
// ----------------------------------------------------------------------------
// hhs_pkg: shared types and constants for the heightmap height sampler
// Store geometry, command codes, register indexes and inter-module structs.
// ----------------------------------------------------------------------------
package hhs_pkg;

  localparam int MAP_DIM     = 257;
  localparam int STORE_DEPTH = MAP_DIM * MAP_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DIM_W       = $clog2(MAP_DIM + 1);
  localparam int IDX_W       = $clog2(MAP_DIM - 1);
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = 56;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [FRAC_W:0] FRAC_ONE = 17'h10000;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  localparam logic [2:0] REG_HALF_WIDTH   = 3'd0;
  localparam logic [2:0] REG_HALF_DEPTH   = 3'd1;
  localparam logic [2:0] REG_INV_SPACING  = 3'd2;
  localparam logic [2:0] REG_GRID_COLUMNS = 3'd3;
  localparam logic [2:0] REG_GRID_ROWS    = 3'd4;

  typedef struct packed {
    logic [30:0] half_width;
    logic [30:0] half_depth;
    logic [23:0] inv_cell_spacing;
    logic [8:0]  grid_columns;
    logic [8:0]  grid_rows;
  } cfg_t;

  // one classified item between front and back
  typedef struct packed {
    cmd_t              cmd;
    logic [16:0]       sample_index;
    logic [15:0]       sample_value;
    logic              out_of_range;
    logic [PROD_W-1:0] prod_col;
    logic [PROD_W-1:0] prod_row;
  } entry_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [8:0] n);
    logic [DIM_W-1:0] r;
    if (n < 9'd2) r = DIM_W'(2);
    else if ({1'b0, n} > 10'(MAP_DIM)) r = DIM_W'(MAP_DIM);
    else r = DIM_W'(n);
    return r;
  endfunction

endpackage

// ----- hw/rtl/hhs_front.sv -----
// ----------------------------------------------------------------------------
// hhs_front: query classification and cell-space scaling
// Range check the position, then scale both offsets by the reciprocal spacing.
// ----------------------------------------------------------------------------
module hhs_front (
  input  logic           clk,
  input  logic           rst_n,
  input  hhs_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_cmd,
  input  logic [16:0]    in_sample_index,
  input  logic [15:0]    in_sample_value,
  input  logic [31:0]    in_pos_x,
  input  logic [31:0]    in_pos_z,
  output logic           push,
  output hhs_pkg::entry_t push_data,
  input  logic           q_full
);
  import hhs_pkg::*;

  logic        en;
  logic        f1_valid_r, f2_valid_r;
  cmd_t        f1_cmd_r;
  logic [16:0] f1_idx_r;
  logic [15:0] f1_val_r;
  logic        f1_oor_r;
  logic [31:0] f1_u_r, f1_v_r;
  entry_t      f2_r;

  logic signed [33:0] u, v;
  logic               oor;

  assign en       = !f2_valid_r || !q_full;
  assign in_ready = en;
  assign push     = f2_valid_r && !q_full;
  assign push_data = f2_r;

  always_comb begin
    u   = {{2{in_pos_x[31]}}, in_pos_x} + {3'b000, cfg.half_width};
    v   = {3'b000, cfg.half_depth} - {{2{in_pos_z[31]}}, in_pos_z};
    oor = u[33] || (u[32:0] > {1'b0, cfg.half_width, 1'b0}) ||
          v[33] || (v[32:0] > {1'b0, cfg.half_depth, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else if (en) begin
      f1_valid_r <= in_valid;
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_cmd_r <= cmd_t'(in_cmd);
      f1_idx_r <= in_sample_index;
      f1_val_r <= in_sample_value;
      f1_oor_r <= oor;
      f1_u_r   <= u[31:0];
      f1_v_r   <= v[31:0];
      f2_r.cmd          <= f1_cmd_r;
      f2_r.sample_index <= f1_idx_r;
      f2_r.sample_value <= f1_val_r;
      f2_r.out_of_range <= f1_oor_r;
      f2_r.prod_col     <= f1_u_r * cfg.inv_cell_spacing;
      f2_r.prod_row     <= f1_v_r * cfg.inv_cell_spacing;
    end
  end

endmodule

// ----- hw/rtl/hhs_queue.sv -----
// ----------------------------------------------------------------------------
// hhs_queue: short FIFO between front and back
// Decouples front stalls from back stalls.
// ----------------------------------------------------------------------------
module hhs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hhs_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output hhs_pkg::entry_t head_data
);
  import hhs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  entry_t           slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full       = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PTR_W+1)'(QUEUE_DEPTH)) else $error("queue count beyond depth");
  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count did not drop");

endmodule

// ----- hw/rtl/hhs_back.sv -----
// ----------------------------------------------------------------------------
// hhs_back: cell lookup, corner reads and triangle interpolation
// Four replicated sample stores give one corner each per cycle while the back is not stalled.
// ----------------------------------------------------------------------------
module hhs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  hhs_pkg::cfg_t   cfg,
  input  logic            head_valid,
  input  hhs_pkg::entry_t head_data,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [23:0]     out_height,
  output logic            out_oor
);
  import hhs_pkg::*;

  logic en;
  logic [DIM_W-1:0] cols, rows, col_last, row_last;

  logic [4:1] vld_r;
  logic [4:1] cmd_r;
  logic [4:1] oor_r;

  // cell split
  logic [IDX_W-1:0] b1_col_r, b1_row_r;
  logic [FRAC_W:0]  b1_s_r, b1_t_r;
  logic [16:0]      b1_idx_r;
  logic [15:0]      b1_val_r;
  // addresses
  logic [ADDR_W-1:0] b2_addr_a_r, b2_addr_b_r, b2_addr_c_r, b2_addr_d_r;
  logic [FRAC_W:0]   b2_s_r, b2_t_r;
  logic              b2_we_r;
  logic [ADDR_W-1:0] b2_widx_r;
  logic [15:0]       b2_val_r;
  // corners
  logic [15:0]      b3_a_r, b3_b_r, b3_c_r, b3_d_r;
  logic [FRAC_W:0]  b3_s_r, b3_t_r;
  // products
  logic signed [34:0] b4_p1_r, b4_p2_r;
  logic [15:0]        b4_base_r;
  // result
  logic [23:0] out_h_r;
  logic        out_oor_r;
  logic        out_valid_r;

  logic [15:0] store_a [STORE_DEPTH];
  logic [15:0] store_b [STORE_DEPTH];
  logic [15:0] store_c [STORE_DEPTH];
  logic [15:0] store_d [STORE_DEPTH];

  logic [39:0] cq_col, cq_row;
  logic [16:0] base;
  logic        upper;
  logic [FRAC_W:0] m1, m2;
  logic signed [16:0] d1, d2;
  logic signed [36:0] acc;
  logic [28:0] h_full;

  assign en        = !out_valid_r || out_ready;
  assign pop       = en && head_valid;
  assign out_valid = out_valid_r;
  assign out_height = out_h_r;
  assign out_oor    = out_oor_r;

  assign cols     = clamp_dim(cfg.grid_columns);
  assign rows     = clamp_dim(cfg.grid_rows);
  assign col_last = cols - DIM_W'(2);
  assign row_last = rows - DIM_W'(2);
  assign cq_col   = head_data.prod_col[PROD_W-1:16];
  assign cq_row   = head_data.prod_row[PROD_W-1:16];
  assign base     = 17'(b1_row_r) * 17'(cols) + 17'(b1_col_r);

  always_comb begin
    upper = ({1'b0, b3_s_r} + {1'b0, b3_t_r}) <= {1'b0, FRAC_ONE};
    m1 = upper ? b3_s_r : FRAC_ONE - b3_s_r;
    m2 = upper ? b3_t_r : FRAC_ONE - b3_t_r;
    d1 = upper ? ({1'b0, b3_b_r} - {1'b0, b3_a_r}) : ({1'b0, b3_c_r} - {1'b0, b3_d_r});
    d2 = upper ? ({1'b0, b3_c_r} - {1'b0, b3_a_r}) : ({1'b0, b3_b_r} - {1'b0, b3_d_r});
    acc = $signed({5'b0, b4_base_r, 16'b0}) + 37'(b4_p1_r) + 37'(b4_p2_r);
    if (acc[36]) h_full = '0;
    else h_full = 29'((acc[35:0] + 36'd128) >> 8);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[3:1], head_valid};
      out_valid_r <= vld_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r <= {cmd_r[3:1], head_data.cmd};
      oor_r <= {oor_r[3:1], head_data.out_of_range};
      // advance: split cell index and fraction, clamp at the far edge
      if (cq_col[39:16] > 24'(col_last)) begin
        b1_col_r <= col_last[IDX_W-1:0];
        b1_s_r   <= FRAC_ONE;
      end else begin
        b1_col_r <= cq_col[16+IDX_W-1:16];
        b1_s_r   <= {1'b0, cq_col[15:0]};
      end
      if (cq_row[39:16] > 24'(row_last)) begin
        b1_row_r <= row_last[IDX_W-1:0];
        b1_t_r   <= FRAC_ONE;
      end else begin
        b1_row_r <= cq_row[16+IDX_W-1:16];
        b1_t_r   <= {1'b0, cq_row[15:0]};
      end
      b1_idx_r <= head_data.sample_index;
      b1_val_r <= head_data.sample_value;

      b2_addr_a_r <= base;
      b2_addr_b_r <= base + 17'd1;
      b2_addr_c_r <= base + 17'(cols);
      b2_addr_d_r <= base + 17'(cols) + 17'd1;
      b2_s_r      <= b1_s_r;
      b2_t_r      <= b1_t_r;
      b2_we_r     <= vld_r[1] && (cmd_r[1] == CMD_WRITE) &&
                     ({15'b0, b1_idx_r} < 32'(STORE_DEPTH));
      b2_widx_r   <= b1_idx_r;
      b2_val_r    <= b1_val_r;

      b3_s_r <= b2_s_r;
      b3_t_r <= b2_t_r;

      b4_p1_r   <= $signed({1'b0, m1}) * d1;
      b4_p2_r   <= $signed({1'b0, m2}) * d2;
      b4_base_r <= upper ? b3_a_r : b3_d_r;

      if (cmd_r[4] == CMD_WRITE || oor_r[4]) out_h_r <= '0;
      else if (h_full > 29'hFFFFFF) out_h_r <= 24'hFFFFFF;
      else out_h_r <= h_full[23:0];
      out_oor_r <= (cmd_r[4] == CMD_QUERY) && oor_r[4];
    end
  end

  // sample stores: same write to each copy, one corner read per copy
  always_ff @(posedge clk) begin
    if (en) begin
      if (b2_we_r) store_a[b2_widx_r] <= b2_val_r;
      b3_a_r <= store_a[b2_addr_a_r];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (b2_we_r) store_b[b2_widx_r] <= b2_val_r;
      b3_b_r <= store_b[b2_addr_b_r];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (b2_we_r) store_c[b2_widx_r] <= b2_val_r;
      b3_c_r <= store_c[b2_addr_c_r];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (b2_we_r) store_d[b2_widx_r] <= b2_val_r;
      b3_d_r <= store_d[b2_addr_d_r];
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(out_h_r) && $stable(out_oor_r))
    else $error("result changed under stall");
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_oor_r) |-> out_h_r == '0)
    else $error("out of range with nonzero height");
  a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> en) else $error("pop while back stalled");

endmodule

// ----- hw/rtl/heightmap_height_sampler.sv -----
// ----------------------------------------------------------------------------
// heightmap_height_sampler: triangle-interpolated terrain height lookup
// Holds a 257x257 grid of 16-bit samples and answers position queries.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per item. in_tuser = command (0 write, 1 query).
//           A write stores sample_value at sample_index; a query samples the
//           terrain at (pos_x, pos_z), Q16.16.
//   out_* : one transaction per item. out_tdata = height (Q16.8),
//           out_tuser = out_of_range. Writes return height 0.
//   cfg_* : register writes, index 0..4 as listed in the package; only while
//           the block is idle. cfg_ready is always high.
// Throughput: one item per cycle while not stalled. The corner lookup reads
//   four replicated sample stores in the same cycle, one corner per store.
// Path: an input transaction passes two front stages, a queue slot, four
//   back stages for cell split, addresses, corner read and products, then
//   the output register.
// Reset: clears valid state and loads the register defaults; the sample
//   store is undefined until written and has no clearing pass.
// Stall: when out_tready is low the back pipeline holds; the 4-entry queue
//   keeps absorbing front transactions until full, then in_tready drops.
// ----------------------------------------------------------------------------
module heightmap_height_sampler (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // sample_index[16:0], sample_value[32:17],
                                   // pos_x[64:33], pos_z[96:65], zero pad
  input  logic         in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,  // height[23:0]
  output logic         out_tuser,  // out_of_range
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data
);
  import hhs_pkg::*;

  cfg_t   cfg_r;
  logic   push, q_full, pop, head_valid;
  entry_t push_data, head_data;

  assign cfg_ready = 1'b1;

  // hold the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_width       <= 31'd8388608;
      cfg_r.half_depth       <= 31'd8388608;
      cfg_r.inv_cell_spacing <= 24'd65536;
      cfg_r.grid_columns     <= 9'd257;
      cfg_r.grid_rows        <= 9'd257;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HALF_WIDTH:   cfg_r.half_width       <= cfg_data;
        REG_HALF_DEPTH:   cfg_r.half_depth       <= cfg_data;
        REG_INV_SPACING:  cfg_r.inv_cell_spacing <= cfg_data[23:0];
        REG_GRID_COLUMNS: cfg_r.grid_columns     <= cfg_data[8:0];
        REG_GRID_ROWS:    cfg_r.grid_rows        <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  hhs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_cmd          (in_tuser),
    .in_sample_index (in_tdata[16:0]),
    .in_sample_value (in_tdata[32:17]),
    .in_pos_x        (in_tdata[64:33]),
    .in_pos_z        (in_tdata[96:65]),
    .push            (push),
    .push_data       (push_data),
    .q_full          (q_full)
  );

  hhs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  hhs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_height (out_tdata),
    .out_oor    (out_tuser)
  );

endmodule
